>>> rtl/core/cfc_pkg.sv
package cfc_pkg;

  localparam int BANK_BYTES      = 4096;
  localparam int DISPLAY_BYTES   = 2048;
  localparam int IMAGE_BYTES_DEF = 10240;
  localparam int DISPLAY_BASE    = 2 * BANK_BYTES;
  localparam int NUM_FETCHERS    = 8;
  localparam int TICK_W          = 32;

  localparam logic [13:0] DISPLAY_LAST = 14'(DISPLAY_BASE + DISPLAY_BYTES - 1);

  localparam logic [1:0] OP_ACCESS  = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_LOAD    = 2'd2;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam logic [12:0] ADDR_READ_BASE  = 13'h1000;
  localparam logic [12:0] ADDR_WRITE_BASE = 13'h1040;
  localparam logic [12:0] ADDR_ROM_BASE   = 13'h1080;
  localparam logic [12:0] ADDR_BANK_LOW   = 13'h1FF8;
  localparam logic [12:0] ADDR_BANK_HIGH  = 13'h1FF9;

  // read functions
  localparam logic [2:0] RF_SOUND   = 3'd0;
  localparam logic [2:0] RF_DISPLAY = 3'd1;
  localparam logic [2:0] RF_MASKED  = 3'd2;
  localparam logic [2:0] RF_FLAG    = 3'd7;

  // write functions
  localparam logic [2:0] WF_TOP      = 3'd0;
  localparam logic [2:0] WF_BOTTOM   = 3'd1;
  localparam logic [2:0] WF_COUNT_LO = 3'd2;
  localparam logic [2:0] WF_COUNT_HI = 3'd3;
  localparam logic [2:0] WF_RAND_RST = 3'd6;

  typedef struct packed {
    logic [7:0]  top;
    logic [7:0]  bottom;
    logic [10:0] count;
    logic        flag;
  } fetcher_t;

  localparam int FETCHER_W = $bits(fetcher_t);

  typedef struct packed {
    logic       busy;
    logic [2:0] flags;
  } mod_stat_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_IMG   = 4'b0100,
    S_WAIT  = 4'b1000
  } state_t;

  function automatic logic [7:0] amp_lookup(input logic [2:0] sel);
    logic [7:0] v;
    case (sel)
      3'd0: v = 8'h00;
      3'd1: v = 8'h04;
      3'd2: v = 8'h05;
      3'd3: v = 8'h09;
      3'd4: v = 8'h06;
      3'd5: v = 8'h0a;
      3'd6: v = 8'h0b;
      3'd7: v = 8'h0f;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_step(input logic [31:0] r);
    logic [31:0] t;
    t = r ^ (r << 3);
    return t ^ 32'($signed(t) >>> 5);
  endfunction

endpackage

>>> rtl/core/cfc_if.sv
interface cfc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [13:0] address;
  logic [7:0]  write_data;

  modport source (output valid, opcode, address, write_data, input ready);
  modport sink   (input valid, opcode, address, write_data, output ready);
endinterface

interface cfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

>>> rtl/core/cfc_ram.sv
module cfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

>>> rtl/core/cfc_modunit.sv
module cfc_modunit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [31:0]           tick,
  input  logic [2:0][7:0]       top,
  input  logic [2:0][7:0]       bottom,
  output cfc_pkg::mod_stat_t    stat
);
  import cfc_pkg::*;

  logic            busy_r, busy_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  logic [31:0]     quo_r, quo_nxt;
  logic [2:0][7:0] top_r, top_nxt;
  logic [2:0][7:0] bot_r, bot_nxt;
  logic [2:0][7:0] rem_r, rem_nxt;
  logic [2:0]      flags_r, flags_nxt;
  logic [2:0][8:0] trial;
  logic [2:0][7:0] rem_step;

  // one dividend bit per cycle, restoring, three lanes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem_r[i], quo_r[31]};
      if (trial[i] >= {1'b0, top_r[i]}) begin
        rem_step[i] = 8'(trial[i] - {1'b0, top_r[i]});
      end else begin
        rem_step[i] = trial[i][7:0];
      end
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    top_nxt   = top_r;
    bot_nxt   = bot_r;
    rem_nxt   = rem_r;
    flags_nxt = flags_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = tick;
      top_nxt  = top;
      bot_nxt  = bottom;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = rem_step;
      quo_nxt = {quo_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        for (int i = 0; i < 3; i++) begin
          flags_nxt[i] = (top_r[i] != 8'd0) && (rem_step[i] > bot_r[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      flags_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
      flags_r <= flags_nxt;
    end
    quo_r <= quo_nxt;
    top_r <= top_nxt;
    bot_r <= bot_nxt;
    rem_r <= rem_nxt;
  end

  assign stat = '{busy: busy_r, flags: flags_r};
endmodule

>>> rtl/core/dpc_cartridge_coprocessor.sv
// Cartridge data-fetcher coprocessor.
// Input channel in_ch carries one item per handshake: opcode (bus access,
// music tick or image load), address and write_data. Result channel out_ch
// carries read_data, one item for each fetcher read (0x1000-0x103F) and each
// ROM read (0x1080-0x1FFF with A12 set); all other items give no result.
// Music ticks, image loads and ignored accesses leave the block idle and ready.
// Every access with A12 set recomputes the three music flags through a
// bit-serial modulo unit (one dividend bit per cycle over 32 bits), so such
// an access keeps the block busy from accept until the modulo unit is done.
// Fetcher state lives in an 8-entry RAM, the image in a single-port-read RAM,
// both with registered read data.
// After reset all fetcher registers read as zero, the random register is 1,
// the first bank is selected and music state is clear; the image RAM holds
// nothing valid until loaded. A result waits in the output register while
// the receiver stalls; the next item is accepted meanwhile, and the block
// holds its own finished result until the output register frees up.
module dpc_cartridge_coprocessor #(
  parameter int IMAGE_BYTES = cfc_pkg::IMAGE_BYTES_DEF
) (
  input logic      clk,
  input logic      rst_n,
  cfc_in_if.sink   in_ch,
  cfc_out_if.source out_ch
);
  import cfc_pkg::*;

  localparam int AW = $clog2(IMAGE_BYTES);

  state_t          state_r, state_nxt;
  logic [31:0]     rand_r, rand_nxt;
  logic [2:0]      mode_r, mode_nxt;
  logic [31:0]     tick_r, tick_nxt;
  logic            bank_r, bank_nxt;
  logic [7:0]      fvalid_r, fvalid_nxt;
  logic [2:0][7:0] mtop_r, mtop_nxt;
  logic [2:0][7:0] mbot_r, mbot_nxt;
  logic [12:0]     addr_r, addr_nxt;
  logic [7:0]      wdat_r, wdat_nxt;
  logic [7:0]      res_r, res_nxt;
  logic            has_res_r, has_res_nxt;
  logic            mask_r, mask_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_data_r, out_data_nxt;

  logic            accept;
  logic [12:0]     in_addr;
  logic            mod_start;
  mod_stat_t       mod_stat;

  logic            f_we;
  logic [2:0]      f_raddr;
  fetcher_t        f_wdata, f_q, f_cur;
  logic [FETCHER_W-1:0] f_rq;

  logic            i_we;
  logic [AW-1:0]   i_waddr, i_raddr;
  logic [7:0]      i_q;

  logic [2:0]      func, idx;
  logic            is_write;
  logic [7:0]      ctr;
  logic [10:0]     cnt_dec;
  logic [13:0]     disp;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_addr   = in_ch.address[12:0];
  assign mod_start = accept && (in_ch.opcode == OP_ACCESS) && in_addr[12];

  assign func     = addr_r[5:3];
  assign idx      = addr_r[2:0];
  assign is_write = addr_r[6];

  assign f_raddr = in_addr[2:0];
  assign f_q     = fetcher_t'(f_rq);
  // unwritten entries read as their reset value
  assign f_cur   = fvalid_r[idx] ? f_q : '0;
  assign ctr     = f_cur.count[7:0];
  assign cnt_dec = f_cur.count - 11'd1;
  assign disp    = DISPLAY_LAST - {3'b000, f_cur.count};

  cfc_ram #(.WIDTH(FETCHER_W), .DEPTH(NUM_FETCHERS)) u_fetch_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (idx),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rq)
  );

  cfc_ram #(.WIDTH(8), .DEPTH(IMAGE_BYTES)) u_image_ram (
    .clk   (clk),
    .we    (i_we),
    .waddr (i_waddr),
    .wdata (in_ch.write_data),
    .raddr (i_raddr),
    .rdata (i_q)
  );

  cfc_modunit u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mod_start),
    .tick   (tick_r),
    .top    (mtop_r),
    .bottom (mbot_r),
    .stat   (mod_stat)
  );

  // image loads only land while idle; reads come from ROM or display fetches
  assign i_we    = accept && (in_ch.opcode == OP_LOAD)
                   && ({18'd0, in_ch.address} < 32'(IMAGE_BYTES));
  assign i_waddr = AW'(in_ch.address);
  assign i_raddr = (state_r == S_FETCH) ? AW'(disp) : AW'({bank_nxt, in_addr[11:0]});

  always_comb begin
    state_nxt     = state_r;
    rand_nxt      = rand_r;
    mode_nxt      = mode_r;
    tick_nxt      = tick_r;
    bank_nxt      = bank_r;
    fvalid_nxt    = fvalid_r;
    mtop_nxt      = mtop_r;
    mbot_nxt      = mbot_r;
    addr_nxt      = addr_r;
    wdat_nxt      = wdat_r;
    res_nxt       = res_r;
    has_res_nxt   = has_res_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    f_we          = 1'b0;
    f_wdata       = f_cur;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          addr_nxt = in_addr;
          wdat_nxt = in_ch.write_data;
          if (in_ch.opcode == OP_TICK) begin
            tick_nxt = tick_r + 32'd1;
          end else if (mod_start) begin
            if (in_addr < ADDR_ROM_BASE) begin
              state_nxt = S_FETCH;
            end else begin
              if (in_addr == ADDR_BANK_LOW) begin
                bank_nxt = 1'b0;
              end else if (in_addr == ADDR_BANK_HIGH) begin
                bank_nxt = 1'b1;
              end
              mask_nxt  = 1'b1;
              state_nxt = S_IMG;
            end
          end
        end
      end

      S_FETCH: begin
        f_we        = 1'b1;
        fvalid_nxt[idx] = 1'b1;
        has_res_nxt = !is_write;
        res_nxt     = 8'h00;
        state_nxt   = S_WAIT;
        if (!is_write) begin
          // clock the counter unless the fetcher is a music generator
          if (!(idx >= 3'd5 && mode_r[2'(idx - 3'd5)])) begin
            f_wdata.count = cnt_dec;
            if (cnt_dec[7:0] == f_cur.top) begin
              f_wdata.flag = 1'b1;
            end else if (cnt_dec[7:0] == f_cur.bottom) begin
              f_wdata.flag = 1'b0;
            end
          end
          case (func)
            RF_SOUND: begin
              if (idx < 3'd4) begin
                rand_nxt = rand_step(rand_r);
                res_nxt  = rand_nxt[7:0];
              end else begin
                res_nxt = amp_lookup(mode_r & mod_stat.flags);
              end
            end
            RF_DISPLAY: begin
              mask_nxt  = 1'b1;
              state_nxt = S_IMG;
            end
            RF_MASKED: begin
              mask_nxt  = f_cur.flag;
              state_nxt = S_IMG;
            end
            RF_FLAG: begin
              res_nxt = f_cur.flag ? 8'hFF : 8'h00;
            end
            default: begin
              res_nxt = 8'h00;
            end
          endcase
        end else begin
          case (func)
            WF_TOP: begin
              f_wdata.top  = wdat_r;
              f_wdata.flag = (ctr == wdat_r);
            end
            WF_BOTTOM: begin
              f_wdata.bottom = wdat_r;
              if (ctr == wdat_r) begin
                f_wdata.flag = 1'b0;
              end
            end
            WF_COUNT_LO: begin
              f_wdata.count = {f_cur.count[10:8], wdat_r};
              if (wdat_r == f_cur.top) begin
                f_wdata.flag = 1'b1;
              end else if (wdat_r == f_cur.bottom) begin
                f_wdata.flag = 1'b0;
              end
            end
            WF_COUNT_HI: begin
              f_wdata.count = {wdat_r[2:0], ctr};
              if (idx >= 3'd5) begin
                mode_nxt[2'(idx - 3'd5)] = wdat_r[4];
              end
            end
            WF_RAND_RST: begin
              rand_nxt = 32'd1;
            end
            default: begin
              f_wdata = f_cur;
            end
          endcase
          // mirror music fetchers' limits for the modulo unit
          if (idx >= 3'd5) begin
            mtop_nxt[2'(idx - 3'd5)] = f_wdata.top;
            mbot_nxt[2'(idx - 3'd5)] = f_wdata.bottom;
          end
        end
      end

      S_IMG: begin
        res_nxt     = mask_r ? i_q : 8'h00;
        has_res_nxt = 1'b1;
        state_nxt   = S_WAIT;
      end

      S_WAIT: begin
        // hold until the flags are in and the output register is free
        if (!mod_stat.busy && (!has_res_r || !out_valid_r || out_ch.ready)) begin
          if (has_res_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = res_r;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rand_r      <= 32'd1;
      mode_r      <= '0;
      tick_r      <= '0;
      bank_r      <= 1'b0;
      fvalid_r    <= '0;
      mtop_r      <= '0;
      mbot_r      <= '0;
      has_res_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rand_r      <= rand_nxt;
      mode_r      <= mode_nxt;
      tick_r      <= tick_nxt;
      bank_r      <= bank_nxt;
      fvalid_r    <= fvalid_nxt;
      mtop_r      <= mtop_nxt;
      mbot_r      <= mbot_nxt;
      has_res_r   <= has_res_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r     <= addr_nxt;
    wdat_r     <= wdat_nxt;
    res_r      <= res_nxt;
    mask_r     <= mask_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;
endmodule
